/* rtl/core/tba_pkg.sv */
`default_nettype none
package tba_pkg;

	localparam int SIZE_W = 21;
	localparam int BS_W = 13;
	localparam int CNT_W = 19;
	localparam int TAG_W = 16;
	localparam int IDX_W = 8;
	localparam int CFG_W = 32;
	localparam logic [BS_W-1:0] BS_MIN = 13'd8;
	localparam logic [BS_W-1:0] BS_MAX = 13'd4096;
	localparam logic [BS_W-1:0] BS_RESET = 13'd64;
	localparam logic [SIZE_W-1:0] BYTES_MAX = 21'h1FFFFF;
	localparam logic REG_BLOCK_SIZE = 1'b0;
	localparam logic REG_FREE_TAG = 1'b1;
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV,
		ST_CNT,
		ST_PROD,
		ST_DECIDE,
		ST_LINK,
		ST_POP,
		ST_APPEND,
		ST_FSCAN,
		ST_FEND,
		ST_FDECIDE,
		ST_FFILL,
		ST_UINIT,
		ST_UREAD,
		ST_USTEP,
		ST_AFILL,
		ST_RSCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic load_rel;
		logic div_start;
		logic mk_cnt;
		logic mk_prod;
		logic rd_head;
		logic pop;
		logic app1;
		logic fit_scan;
		logic fit_end;
		logic take_fit;
		logic take_app;
		logic fill;
		logic afill;
		logic u_init;
		logic rd_node;
		logic u_step;
		logic rel_scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic single;
		logic too_big;
		logic head_ok;
		logic room_one;
		logic room_multi;
		logic scan_done;
		logic found;
		logic fill_last;
		logic u_go;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/core/tba_div.sv */
`default_nettype none
module tba_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tba_pkg::SIZE_W-1:0] dividend,
	input  wire logic [tba_pkg::BS_W-1:0]   divisor,
	output logic                           done,
	output logic [tba_pkg::SIZE_W-1:0]      quotient,
	output logic [tba_pkg::BS_W-1:0]        remainder
);
	import tba_pkg::*;

	localparam int STEP_W = $clog2(SIZE_W + 1);

	logic [BS_W-1:0] div_q;
	logic [BS_W-1:0] rem_q;
	logic [SIZE_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic run_q;
	logic done_q;
	logic [BS_W:0] trial;
	logic ge;

	assign trial = {rem_q, quo_q[SIZE_W-1]};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= STEP_W'(SIZE_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? BS_W'(trial - {1'b0, div_q}) : trial[BS_W-1:0];
			quo_q <= {quo_q[SIZE_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* rtl/core/tba_ctrl.sv */
`default_nettype none
module tba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           func,
	input  wire tba_pkg::stat_t stat,
	output tba_pkg::cmd_t       cmd,
	output logic                busy
);
	import tba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (func == FUNC_RELEASE) ? ST_RSCAN : ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: state_d = ST_PROD;
			ST_PROD: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (stat.single) begin
					if (stat.head_ok) begin
						state_d = ST_LINK;
					end else if (stat.room_one) begin
						state_d = ST_APPEND;
					end else begin
						state_d = ST_FIN;
					end
				end else if (stat.too_big) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_FSCAN;
				end
			end
			ST_LINK: state_d = ST_POP;
			ST_POP: state_d = ST_FIN;
			ST_APPEND: state_d = ST_FIN;
			ST_FSCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FEND;
				end
			end
			ST_FEND: state_d = ST_FDECIDE;
			ST_FDECIDE: begin
				if (stat.found) begin
					state_d = ST_FFILL;
				end else if (stat.room_multi) begin
					state_d = ST_AFILL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FFILL: begin
				if (stat.fill_last) begin
					state_d = ST_UINIT;
				end
			end
			ST_UINIT: state_d = ST_UREAD;
			ST_UREAD: state_d = stat.u_go ? ST_USTEP : ST_FIN;
			ST_USTEP: state_d = ST_UREAD;
			ST_AFILL: begin
				if (stat.fill_last) begin
					state_d = ST_FIN;
				end
			end
			ST_RSCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				cmd.load_rel = start && (func == FUNC_RELEASE);
				cmd.div_start = start && (func == FUNC_ALLOC);
			end
			ST_CNT: cmd.mk_cnt = 1'b1;
			ST_PROD: cmd.mk_prod = 1'b1;
			ST_LINK: cmd.rd_head = 1'b1;
			ST_POP: cmd.pop = 1'b1;
			ST_APPEND: cmd.app1 = 1'b1;
			ST_FSCAN: cmd.fit_scan = 1'b1;
			ST_FEND: cmd.fit_end = 1'b1;
			ST_FDECIDE: begin
				cmd.take_fit = stat.found;
				cmd.take_app = !stat.found && stat.room_multi;
			end
			ST_FFILL: cmd.fill = 1'b1;
			ST_UINIT: cmd.u_init = 1'b1;
			ST_UREAD: cmd.rd_node = 1'b1;
			ST_USTEP: cmd.u_step = 1'b1;
			ST_AFILL: cmd.afill = 1'b1;
			ST_RSCAN: cmd.rel_scan = 1'b1;
			ST_FIN: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
endmodule
`default_nettype wire

/* rtl/core/tba_dp.sv */
`default_nettype none
module tba_dp #(
	parameter int POOL_BLOCKS = 256,
	parameter int TAG_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tba_pkg::cmd_t             cmd,
	output tba_pkg::stat_t                 stat,
	input  wire logic [tba_pkg::TAG_W-1:0]  tag,
	input  wire logic [tba_pkg::SIZE_W-1:0] size_bytes,
	input  wire logic [tba_pkg::BS_W-1:0]   block_size,
	input  wire logic [tba_pkg::TAG_W-1:0]  free_tag,
	output logic                           done,
	output logic                           ok,
	output logic [tba_pkg::IDX_W-1:0]       block_index,
	output logic [tba_pkg::SIZE_W-1:0]      allocated_bytes
);
	import tba_pkg::*;

	localparam int IW = $clog2(POOL_BLOCKS);
	localparam int PW = $clog2(POOL_BLOCKS + 1);
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam logic [PW-1:0] POOL = PW'(POOL_BLOCKS);

	logic [TW-1:0] tag_mem [POOL_BLOCKS];
	logic occ_mem [POOL_BLOCKS];
	logic [PW-1:0] run_mem [POOL_BLOCKS];
	logic [PW-1:0] link_mem [POOL_BLOCKS];

	logic [TW-1:0] tag_rd_q;
	logic occ_rd_q;
	logic [PW-1:0] run_rd_q;
	logic [PW-1:0] link_rd_q;

	logic [TW-1:0] tag_q;
	logic [PW-1:0] used_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] ctr_q;
	logic pv_q;
	logic [PW-1:0] pi_q;
	logic [PW-1:0] run_q;
	logic [PW-1:0] best_q;
	logic found_q;
	logic [PW-1:0] fidx_q;
	logic [PW-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SIZE_W-1:0] alloc_q;
	logic ok_q;
	logic done_q;
	logic [PW-1:0] node_q;
	logic [PW-1:0] prev_q;
	logic prev_v_q;
	logic [PW-1:0] steps_q;

	logic [BS_W-1:0] bs_eff;
	logic div_done;
	logic [SIZE_W-1:0] quo;
	logic [BS_W-1:0] rem;
	logic [31:0] prod;
	logic [PW-1:0] cn;
	logic [PW-1:0] rd_addr;
	logic [PW-1:0] base_wa;
	logic issue;
	logic [PW:0] run1;
	logic fits_occ;
	logic fits_end;
	logic fits_tail;
	logic cont;
	logic rel_hit;
	logic in_range;
	logic [IW+IDX_W-1:0] idx_ext;

	logic occ_we;
	logic [IW-1:0] occ_wa;
	logic occ_wd;
	logic tag_we;
	logic [IW-1:0] tag_wa;
	logic [TW-1:0] tag_wd;
	logic run_we;
	logic [IW-1:0] run_wa;
	logic [PW-1:0] run_wd;
	logic link_we;
	logic [IW-1:0] link_wa;
	logic [PW-1:0] link_wd;

	assign bs_eff = (block_size < BS_MIN) ? BS_MIN : ((block_size > BS_MAX) ? BS_MAX : block_size);

	tba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (size_bytes),
		.divisor   (bs_eff),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign prod = 32'(cnt_q) * 32'(bs_eff);
	assign cn = cnt_q[PW-1:0];
	assign rd_addr = cmd.rd_head ? head_q : (cmd.rd_node ? node_q : ctr_q);
	assign base_wa = (cmd.fill ? idx_q : used_q) + ctr_q;
	assign issue = (cmd.fit_scan || cmd.rel_scan) && (ctr_q < used_q);

	assign run1 = {1'b0, run_q} + 1'b1;
	assign fits_occ = (run_q >= cn) && (!found_q || run_q <= best_q);
	assign fits_tail = (run1 >= {1'b0, cn}) && (!found_q || run1 <= {1'b0, best_q});
	assign fits_end = fits_occ;
	assign cont = ({1'b0, run_rd_q} + {1'b0, run_q}) >= {1'b0, cn};
	assign rel_hit = cmd.rel_scan && pv_q && occ_rd_q && (tag_rd_q == tag_q);
	assign in_range = (node_q >= fidx_q) && ((node_q - fidx_q) < cn);

	always_comb begin
		occ_we = 1'b0;
		occ_wa = used_q[IW-1:0];
		occ_wd = 1'b1;
		tag_we = 1'b0;
		tag_wa = used_q[IW-1:0];
		tag_wd = tag_q;
		run_we = 1'b0;
		run_wa = used_q[IW-1:0];
		run_wd = PW'(1);
		link_we = 1'b0;
		link_wa = pi_q[IW-1:0];
		link_wd = head_q;
		if (cmd.pop) begin
			occ_we = 1'b1;
			occ_wa = head_q[IW-1:0];
			tag_we = 1'b1;
			tag_wa = head_q[IW-1:0];
		end
		if (cmd.app1) begin
			occ_we = 1'b1;
			tag_we = 1'b1;
			run_we = 1'b1;
		end
		if (cmd.fill || cmd.afill) begin
			occ_we = 1'b1;
			occ_wa = base_wa[IW-1:0];
			tag_we = 1'b1;
			tag_wa = base_wa[IW-1:0];
		end
		if (cmd.afill) begin
			run_we = 1'b1;
			run_wa = base_wa[IW-1:0];
			run_wd = cn - ctr_q;
		end
		if (rel_hit) begin
			occ_we = 1'b1;
			occ_wa = pi_q[IW-1:0];
			occ_wd = 1'b0;
			tag_we = 1'b1;
			tag_wa = pi_q[IW-1:0];
			tag_wd = free_tag[TW-1:0];
			link_we = 1'b1;
		end
		if (cmd.u_step && in_range && prev_v_q) begin
			link_we = 1'b1;
			link_wa = prev_q[IW-1:0];
			link_wd = link_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (run_we) begin
			run_mem[run_wa] <= run_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		occ_rd_q <= occ_mem[rd_addr[IW-1:0]];
		tag_rd_q <= tag_mem[rd_addr[IW-1:0]];
		run_rd_q <= run_mem[rd_addr[IW-1:0]];
		link_rd_q <= link_mem[rd_addr[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q <= tag[TW-1:0];
		end
		if (cmd.mk_cnt) begin
			cnt_q <= quo[CNT_W-1:0] + CNT_W'(rem != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			head_q <= POOL;
			ctr_q <= '0;
			pv_q <= 1'b0;
			pi_q <= '0;
			run_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			fidx_q <= '0;
			idx_q <= '0;
			alloc_q <= '0;
			ok_q <= 1'b0;
			done_q <= 1'b0;
			node_q <= '0;
			prev_q <= '0;
			prev_v_q <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= cmd.emit;
			pv_q <= issue;
			if (issue) begin
				pi_q <= ctr_q;
				ctr_q <= ctr_q + 1'b1;
			end
			if (cmd.load) begin
				ok_q <= cmd.load_rel;
				idx_q <= '0;
				alloc_q <= '0;
				ctr_q <= '0;
				pv_q <= 1'b0;
				run_q <= '0;
				best_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.mk_prod) begin
				alloc_q <= (prod > 32'(BYTES_MAX)) ? BYTES_MAX : prod[SIZE_W-1:0];
			end
			if (cmd.pop) begin
				idx_q <= head_q;
				head_q <= link_rd_q;
				ok_q <= 1'b1;
			end
			if (cmd.app1) begin
				idx_q <= used_q;
				used_q <= used_q + 1'b1;
				ok_q <= 1'b1;
			end
			if (cmd.fit_scan && pv_q) begin
				if (occ_rd_q) begin
					if (fits_occ) begin
						fidx_q <= pi_q - cn;
						best_q <= run_q;
						found_q <= 1'b1;
					end
					run_q <= '0;
				end else if (cont) begin
					if (run_rd_q == PW'(1)) begin
						if (fits_tail) begin
							fidx_q <= pi_q + 1'b1 - cn;
							best_q <= run1[PW-1:0];
							found_q <= 1'b1;
						end
						run_q <= '0;
					end else begin
						run_q <= run1[PW-1:0];
					end
				end else begin
					run_q <= '0;
				end
			end
			if (cmd.fit_end && fits_end) begin
				fidx_q <= used_q - cn;
				found_q <= 1'b1;
			end
			if (cmd.take_fit) begin
				idx_q <= fidx_q;
				ok_q <= 1'b1;
				ctr_q <= '0;
			end
			if (cmd.take_app) begin
				idx_q <= used_q;
				ok_q <= 1'b1;
				ctr_q <= '0;
			end
			if (cmd.fill) begin
				ctr_q <= ctr_q + 1'b1;
			end
			if (cmd.afill) begin
				ctr_q <= ctr_q + 1'b1;
				if (ctr_q == cn - 1'b1) begin
					used_q <= used_q + cn;
				end
			end
			if (cmd.u_init) begin
				node_q <= head_q;
				prev_v_q <= 1'b0;
				steps_q <= '0;
			end
			if (cmd.u_step) begin
				if (in_range) begin
					if (!prev_v_q) begin
						head_q <= link_rd_q;
					end
				end else begin
					prev_q <= node_q;
					prev_v_q <= 1'b1;
				end
				node_q <= link_rd_q;
				steps_q <= steps_q + 1'b1;
			end
			if (rel_hit) begin
				head_q <= pi_q;
			end
		end
	end

	always_comb begin
		stat = '0;
		stat.div_done = div_done;
		stat.single = cnt_q <= CNT_W'(1);
		stat.too_big = cnt_q > CNT_W'(POOL_BLOCKS);
		stat.head_ok = head_q < used_q;
		stat.room_one = used_q < POOL;
		stat.room_multi = cn <= (POOL - used_q);
		stat.scan_done = !pv_q && (ctr_q >= used_q);
		stat.found = found_q;
		stat.fill_last = ctr_q == (cn - 1'b1);
		stat.u_go = (steps_q < POOL) && (node_q < used_q);
	end

	assign idx_ext = {{IDX_W{1'b0}}, idx_q[IW-1:0]};
	assign done = done_q;
	assign ok = ok_q;
	assign block_index = idx_ext[IDX_W-1:0];
	assign allocated_bytes = alloc_q;
endmodule
`default_nettype wire

/* rtl/core/tagged_block_allocator.sv */
`default_nettype none
// Tagged block pool allocator with a command-style item channel and an APB register port.
// Raise start with func, tag and size_bytes; the item is taken when busy is low.
// An allocate item divides the size by the block size in a bit-serial divider,
// then forms the rounded-up block count and the byte total from it.
// A single block is popped from the free list or appended after the used blocks.
// Several blocks run a best-fit scan over the pool at one block per cycle, then write the
// blocks one per cycle and walk the free list to unlink them, or append them if none fits.
// A release item scans the pool at one block per cycle and pushes matching blocks.
// Both scans are bounded by the memory port of the pool tables, read one entry per cycle.
// Each result is shown for one cycle with done high; the receiver cannot stall it.
// busy is low in that cycle, so the next item may be taken at the same edge.
// Reset empties the pool and the free list at once; block_size resets to 64, free_tag to 0.
// Registers: block_size at address 0, free_tag at address 4; write only while idle.
module tagged_block_allocator #(
	parameter int POOL_BLOCKS = 256,
	parameter int TAG_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      func,
	input  wire logic [tba_pkg::TAG_W-1:0]  tag,
	input  wire logic [tba_pkg::SIZE_W-1:0] size_bytes,
	output logic                           done,
	output logic                           ok,
	output logic [tba_pkg::IDX_W-1:0]       block_index,
	output logic [tba_pkg::SIZE_W-1:0]      allocated_bytes,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [tba_pkg::CFG_W-1:0]  pwdata,
	output logic [tba_pkg::CFG_W-1:0]       prdata,
	output logic                           pready
);
	import tba_pkg::*;

	logic [BS_W-1:0] bs_q;
	logic [TAG_W-1:0] ftag_q;
	logic cfg_wr;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= BS_RESET;
			ftag_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BLOCK_SIZE: bs_q <= pwdata[BS_W-1:0];
				REG_FREE_TAG: ftag_q <= pwdata[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLOCK_SIZE: prdata = CFG_W'(bs_q);
			REG_FREE_TAG: prdata = CFG_W'(ftag_q);
			default: prdata = '0;
		endcase
	end

	tba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tba_dp #(
		.POOL_BLOCKS (POOL_BLOCKS),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.tag             (tag),
		.size_bytes      (size_bytes),
		.block_size      (bs_q),
		.free_tag        (ftag_q),
		.done            (done),
		.ok              (ok),
		.block_index     (block_index),
		.allocated_bytes (allocated_bytes)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside an item");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> block_index == '0)
		else $error("failed allocation reports a block index");
endmodule
`default_nettype wire
